FILE: hdl/gnh_pkg.sv
package gnh_pkg;

    localparam logic GNH_OP_LOAD   = 1'b0;
    localparam logic GNH_OP_EXPAND = 1'b1;

    localparam logic [1:0] GNH_REG_MODE   = 2'd0;
    localparam logic [1:0] GNH_REG_HEIGHT = 2'd1;
    localparam logic [1:0] GNH_REG_WIDTH  = 2'd2;

    localparam logic [7:0]  OBSTACLE_CHAR = 8'd64;
    localparam logic [14:0] OCT_FRAC      = 15'd27146;
    localparam logic [8:0]  DIV3_MUL      = 9'd171;
    localparam logic [8:0]  SIZE_RESET    = 9'd256;

    localparam int QDEPTH = 4;
    localparam int QPW    = 2;

    localparam logic [1:0] NB_PREV = 2'd0;
    localparam logic [1:0] NB_SAME = 2'd1;
    localparam logic [1:0] NB_NEXT = 2'd2;

    // Neighbor order: down, right, up, left, down-right, down-left, up-right, up-left.
    localparam logic [1:0] DIR_ROW_SEL [8] = '{NB_NEXT, NB_SAME, NB_PREV, NB_SAME,
                                               NB_NEXT, NB_NEXT, NB_PREV, NB_PREV};
    localparam logic [1:0] DIR_COL_SEL [8] = '{NB_SAME, NB_NEXT, NB_SAME, NB_PREV,
                                               NB_NEXT, NB_PREV, NB_NEXT, NB_PREV};

    typedef struct packed {
        logic       is_expand;
        logic       octile;
        logic       store_ok;
        logic       obstacle;
        logic [6:0] row_q;
        logic [1:0] row_m;
        logic [6:0] col_q;
        logic [1:0] col_m;
        logic [7:0] inb;
        logic [7:0] hi;
        logic [7:0] lo;
    } entry_t;

    function automatic logic [1:0] nb_mod(input logic [1:0] m, input logic [1:0] sel);
        logic [1:0] r;
        r = m;
        case (sel)
            NB_PREV: r = (m == 2'd0) ? 2'd2 : m - 2'd1;
            NB_NEXT: r = (m == 2'd2) ? 2'd0 : m + 2'd1;
            default: r = m;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/grid_neighbor_heuristic_unit.sv
// Grid neighbor expansion unit for A* search.
// The slave stream carries one item per transfer; s_tuser selects a load (0) or an
// expand (1). A load stores one map cell as an obstacle when its character is '@'.
// An expand returns one result on the master stream: the mask of free in-map
// neighbors (four or eight per movement mode), their count, and the Manhattan or
// octile distance to the goal with 8 fractional bits. Loads produce no result.
// The APB port holds the movement mode, the rows in use and the columns in use at
// 0x0, 0x4 and 0x8; write them only while no expand is outstanding.
// Items enter a four-entry queue and one item leaves it per cycle, so the unit sustains
// one transfer per cycle while the result stage is not stalled. An expand leaves the
// queue with the bank read into the first stage, and its result is formed in the
// output register that drives m_tvalid. Nine banks, one per row and column residue
// modulo three, each give one neighbor per cycle, on a read, through a single read port.
// When m_tready is low the result register holds, one expand waits behind it, loads
// ahead of the next expand still drain, and s_tready falls once four items wait in the
// queue. Reset empties the queue and the result stage and sets four-way mode with a
// 256 by 256 map; map contents are unknown until loaded.
module grid_neighbor_heuristic_unit #(
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_WIDTH  = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // cell_row, cell_col, cell_char, goal_row, goal_col
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // neighbor_mask, neighbor_count, goal_distance, zero fill
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic            movement_mode_reg;
    logic [8:0]      row_limit_reg;
    logic [8:0]      col_limit_reg;
    logic            cfg_write;
    gnh_pkg::entry_t front_entry;
    gnh_pkg::entry_t head;
    logic            head_valid;
    logic            pop;
    logic [7:0]      neighbor_mask;
    logic [3:0]      neighbor_count;
    logic [16:0]     goal_distance;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            movement_mode_reg <= 1'b0;
            row_limit_reg     <= gnh_pkg::SIZE_RESET;
            col_limit_reg     <= gnh_pkg::SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                gnh_pkg::GNH_REG_MODE:   movement_mode_reg <= pwdata[0];
                gnh_pkg::GNH_REG_HEIGHT: row_limit_reg     <= pwdata[8:0];
                gnh_pkg::GNH_REG_WIDTH:  col_limit_reg     <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            gnh_pkg::GNH_REG_MODE:   prdata = {31'd0, movement_mode_reg};
            gnh_pkg::GNH_REG_HEIGHT: prdata = {23'd0, row_limit_reg};
            gnh_pkg::GNH_REG_WIDTH:  prdata = {23'd0, col_limit_reg};
            default:                 prdata = '0;
        endcase
    end

    gnh_front #(
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .op           (s_tuser),
        .cell_row     (s_tdata[7:0]),
        .cell_col     (s_tdata[15:8]),
        .cell_char    (s_tdata[23:16]),
        .goal_row     (s_tdata[31:24]),
        .goal_col     (s_tdata[39:32]),
        .movement_mode(movement_mode_reg),
        .row_limit    (row_limit_reg),
        .col_limit    (col_limit_reg),
        .entry        (front_entry)
    );

    gnh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .push_entry(front_entry),
        .push_ready(s_tready),
        .pop       (pop),
        .head      (head),
        .head_valid(head_valid)
    );

    gnh_back #(
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .head_valid(head_valid),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_mask  (neighbor_mask),
        .out_count (neighbor_count),
        .out_dist  (goal_distance)
    );

    assign m_tdata = {3'd0, goal_distance, neighbor_count, neighbor_mask};

endmodule

FILE: hdl/gnh_front.sv
module gnh_front #(
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_WIDTH  = 256
) (
    input  logic           op,
    input  logic [7:0]     cell_row,
    input  logic [7:0]     cell_col,
    input  logic [7:0]     cell_char,
    input  logic [7:0]     goal_row,
    input  logic [7:0]     goal_col,
    input  logic           movement_mode,
    input  logic [8:0]     row_limit,
    input  logic [8:0]     col_limit,
    output gnh_pkg::entry_t entry
);

    function automatic logic in_range(input logic [9:0] v, input logic [8:0] lim,
                                      input int unsigned maxv);
        return (v < {1'b0, lim}) && (32'(v) < maxv);
    endfunction

    logic [16:0] row_prod;
    logic [16:0] col_prod;
    logic [6:0]  row_q;
    logic [6:0]  col_q;
    logic [2:0]  rv;
    logic [2:0]  cv;
    logic [7:0]  dr;
    logic [7:0]  dc;

    assign row_prod = 17'(cell_row) * 17'(gnh_pkg::DIV3_MUL);
    assign col_prod = 17'(cell_col) * 17'(gnh_pkg::DIV3_MUL);
    assign row_q    = row_prod[15:9];
    assign col_q    = col_prod[15:9];

    assign rv[0] = (cell_row != 8'd0)
                   && in_range(10'(cell_row) - 10'd1, row_limit, MAX_HEIGHT);
    assign rv[1] = in_range(10'(cell_row), row_limit, MAX_HEIGHT);
    assign rv[2] = in_range(10'(cell_row) + 10'd1, row_limit, MAX_HEIGHT);
    assign cv[0] = (cell_col != 8'd0)
                   && in_range(10'(cell_col) - 10'd1, col_limit, MAX_WIDTH);
    assign cv[1] = in_range(10'(cell_col), col_limit, MAX_WIDTH);
    assign cv[2] = in_range(10'(cell_col) + 10'd1, col_limit, MAX_WIDTH);

    assign dr = (cell_row > goal_row) ? cell_row - goal_row : goal_row - cell_row;
    assign dc = (cell_col > goal_col) ? cell_col - goal_col : goal_col - cell_col;

    always_comb
    begin
        entry.is_expand = (op == gnh_pkg::GNH_OP_EXPAND);
        entry.octile    = movement_mode;
        entry.store_ok  = (32'(cell_row) < MAX_HEIGHT) && (32'(cell_col) < MAX_WIDTH);
        entry.obstacle  = (cell_char == gnh_pkg::OBSTACLE_CHAR);
        entry.row_q     = row_q;
        entry.row_m     = 2'(cell_row - 8'(row_q) * 8'd3);
        entry.col_q     = col_q;
        entry.col_m     = 2'(cell_col - 8'(col_q) * 8'd3);
        for (int k = 0; k < 8; k++)
        begin
            entry.inb[k] = rv[gnh_pkg::DIR_ROW_SEL[k]] && cv[gnh_pkg::DIR_COL_SEL[k]]
                           && ((k < 4) || movement_mode);
        end
        if (movement_mode)
        begin
            entry.hi = (dr > dc) ? dr : dc;
            entry.lo = (dr > dc) ? dc : dr;
        end
        else
        begin
            entry.hi = dr;
            entry.lo = dc;
        end
    end

endmodule

FILE: hdl/gnh_queue.sv
module gnh_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gnh_pkg::entry_t push_entry,
    output logic            push_ready,
    input  logic            pop,
    output gnh_pkg::entry_t head,
    output logic            head_valid
);

    gnh_pkg::entry_t                entries_reg [gnh_pkg::QDEPTH];
    logic [gnh_pkg::QPW-1:0]        wr_ptr_reg;
    logic [gnh_pkg::QPW-1:0]        wr_ptr_next;
    logic [gnh_pkg::QPW-1:0]        rd_ptr_reg;
    logic [gnh_pkg::QPW-1:0]        rd_ptr_next;
    logic [gnh_pkg::QPW:0]          count_reg;
    logic [gnh_pkg::QPW:0]          count_next;
    logic                           do_push;
    logic                           do_pop;

    assign push_ready = (count_reg != (gnh_pkg::QPW+1)'(gnh_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: hdl/gnh_back.sv
module gnh_back #(
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_WIDTH  = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  gnh_pkg::entry_t head,
    input  logic            head_valid,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_mask,
    output logic [3:0]      out_count,
    output logic [16:0]     out_dist
);

    localparam int EFF_H     = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
    localparam int EFF_W     = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int BANK_ROWS = (EFF_H + 2) / 3;
    localparam int BANK_COLS = (EFF_W + 2) / 3;
    localparam int DEPTH     = BANK_ROWS * BANK_COLS;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [AW-1:0] addr [3][3];
    logic [8:0]    wr_en;
    wire  [8:0]    rd_flat;
    logic [6:0]    bank_rq [3];
    logic [6:0]    bank_cq [3];
    logic          issue_read;
    logic          out_free;
    logic          b1_free;
    logic          b1_adv;

    logic          b1_valid_reg;
    logic          b1_octile_reg;
    logic [1:0]    b1_mrow_reg;
    logic [1:0]    b1_mcol_reg;
    logic [7:0]    b1_inb_reg;
    logic [7:0]    b1_hi_reg;
    logic [7:0]    b1_lo_reg;
    logic [22:0]   b1_prod_reg;

    logic          out_valid_reg;
    logic [7:0]    out_mask_reg;
    logic [7:0]    out_mask_next;
    logic [3:0]    out_count_reg;
    logic [3:0]    out_count_next;
    logic [16:0]   out_dist_reg;
    logic [16:0]   out_dist_next;

    assign out_free   = !out_valid_reg || out_ready;
    assign b1_adv     = b1_valid_reg && out_free;
    assign b1_free    = !b1_valid_reg || out_free;
    assign pop        = head_valid && (!head.is_expand || b1_free);
    assign issue_read = pop && head.is_expand;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (2'(a) == head.row_m)
                bank_rq[a] = head.row_q;
            else if (2'(a) == gnh_pkg::nb_mod(head.row_m, gnh_pkg::NB_PREV))
                bank_rq[a] = head.row_q - 7'(head.row_m == 2'd0);
            else
                bank_rq[a] = head.row_q + 7'(head.row_m == 2'd2);
            if (2'(a) == head.col_m)
                bank_cq[a] = head.col_q;
            else if (2'(a) == gnh_pkg::nb_mod(head.col_m, gnh_pkg::NB_PREV))
                bank_cq[a] = head.col_q - 7'(head.col_m == 2'd0);
            else
                bank_cq[a] = head.col_q + 7'(head.col_m == 2'd2);
        end
        for (int a = 0; a < 3; a++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                addr[a][b]    = AW'(32'(bank_rq[a]) * BANK_COLS + 32'(bank_cq[b]));
                wr_en[a*3+b]  = pop && !head.is_expand && head.store_ok
                                && (head.row_m == 2'(a)) && (head.col_m == 2'(b));
            end
        end
    end

    for (genvar ga = 0; ga < 3; ga++)
    begin : g_row_bank
        for (genvar gb = 0; gb < 3; gb++)
        begin : g_col_bank
            logic mem [DEPTH];
            logic rd_bit_reg;

            always_ff @(posedge clk)
            begin
                if (wr_en[ga*3+gb])
                begin
                    mem[addr[ga][gb]] <= head.obstacle;
                end
                if (issue_read)
                begin
                    rd_bit_reg <= mem[addr[ga][gb]];
                end
            end

            assign rd_flat[ga*3+gb] = rd_bit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (b1_free)
            begin
                b1_valid_reg <= issue_read;
            end
            if (out_free)
            begin
                out_valid_reg <= b1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_read)
        begin
            b1_octile_reg <= head.octile;
            b1_mrow_reg   <= head.row_m;
            b1_mcol_reg   <= head.col_m;
            b1_inb_reg    <= head.inb;
            b1_hi_reg     <= head.hi;
            b1_lo_reg     <= head.lo;
            b1_prod_reg   <= 23'(head.lo) * 23'(gnh_pkg::OCT_FRAC);
        end
        if (b1_adv)
        begin
            out_mask_reg  <= out_mask_next;
            out_count_reg <= out_count_next;
            out_dist_reg  <= out_dist_next;
        end
    end

    always_comb
    begin
        logic [1:0] ra;
        logic [1:0] cb;
        logic [3:0] idx;
        out_count_next = '0;
        for (int k = 0; k < 8; k++)
        begin
            ra  = gnh_pkg::nb_mod(b1_mrow_reg, gnh_pkg::DIR_ROW_SEL[k]);
            cb  = gnh_pkg::nb_mod(b1_mcol_reg, gnh_pkg::DIR_COL_SEL[k]);
            idx = 4'(ra) * 4'd3 + 4'(cb);
            out_mask_next[k] = b1_inb_reg[k] && !rd_flat[idx];
            out_count_next   = out_count_next + 4'(out_mask_next[k]);
        end
        if (b1_octile_reg)
            out_dist_next = {1'b0, b1_hi_reg, 8'd0} + 17'(b1_prod_reg[22:8]);
        else
            out_dist_next = {9'(b1_hi_reg) + 9'(b1_lo_reg), 8'd0};
    end

    assign out_valid = out_valid_reg;
    assign out_mask  = out_mask_reg;
    assign out_count = out_count_reg;
    assign out_dist  = out_dist_reg;

`ifndef SYNTHESIS
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_count_reg == 4'($countones(out_mask_reg))))
        else $error("Neighbor count disagrees with the mask.");

    a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(wr_en))
        else $error("More than one bank written in a cycle.");

    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en != '0) |-> !issue_read)
        else $error("Bank write and read issued together.");

    a_read_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (b1_valid_reg && !out_free) |=> ($past(rd_flat) === rd_flat))
        else $error("Read data changed while the result stage was stalled.");
`endif

endmodule
